// ----- src/lbls_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lbls_pkg: shared types and constants
// Widths, band count, request types and the log helper for the band level
// smoother.
// ----------------------------------------------------------------------------
package lbls_pkg;

	localparam int NUM_BANDS = 8;
	localparam int ENERGY_W = 32;
	localparam int LEVEL_W = 17;
	localparam int RANGE_W = 64;
	localparam int LOG_W = 22;
	localparam int QUOT_W = 17;
	localparam int BAND_IDX_W = 3;
	localparam int ALPHA_W = 17;
	localparam int DEF_SMOOTH_ALPHA = 9830;
	localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [RANGE_W-1:0] RANGE_RESET = 64'h0001_0000_0000_0000;

	typedef logic [ENERGY_W-1:0] energy_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [LOG_W-1:0] log_t;

	// Input request: one frame of band energies, in band order.
	typedef struct packed {
		energy_t sub_bass_energy;
		energy_t bass_energy;
		energy_t low_mid_energy;
		energy_t mid_energy;
		energy_t high_mid_energy;
		energy_t presence_energy;
		energy_t brilliance_energy;
		energy_t air_energy;
	} frame_t;

	// Output request: the smoothed levels, in band order.
	typedef struct packed {
		level_t sub_bass_level;
		level_t bass_level;
		level_t low_mid_level;
		level_t mid_level;
		level_t high_mid_level;
		level_t presence_level;
		level_t brilliance_level;
		level_t air_level;
	} levels_t;

	// Lane sequencing: log, division, smoothing update.
	typedef enum logic [1:0] {L_IDLE, L_LOG, L_DIV, L_SMOOTH} lane_state_t;

	// Lane control from the top: start a lane sequence; its energy operand is valid.
	typedef struct packed {
		logic start;
	} lane_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lane_sts_t;

	// Mitchell approximation of log2(x + 1.0) in Q6.16.
	function automatic log_t mitchell_log(input energy_t x);
		logic [32:0] y;
		logic [32:0] m;
		logic [4:0] p;
		logic [32:0] frac;
		y = {1'b0, x} + 33'd65536;
		p = 5'd16;
		for (int i = 17; i <= 32; i++) begin
			if (y[i]) p = 5'(i);
		end
		m = y & ~(33'd1 << p);
		frac = m >> (p - 5'd16);
		mitchell_log = LOG_W'({p - 5'd16, 16'd0}) + LOG_W'(frac[15:0]);
	endfunction

endpackage
`default_nettype wire

// ----- src/lbls_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lbls_if: valid/ready channel
// Carries one request of parameterized payload between source and sink.
// ----------------------------------------------------------------------------
interface lbls_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/lbls_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lbls_lane: one band's normalize and smoothing lane
// Log stage, restoring divider one bit per cycle, then clamp and smoothing.
// ----------------------------------------------------------------------------
module lbls_lane #(
	parameter int SMOOTH_ALPHA = lbls_pkg::DEF_SMOOTH_ALPHA
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lbls_pkg::lane_ctl_t ctl,
	input wire lbls_pkg::energy_t energy,
	input wire logic [lbls_pkg::RANGE_W-1:0] range,
	output lbls_pkg::lane_sts_t sts,
	output lbls_pkg::level_t level
);
	localparam int NUM_W = 40;
	localparam int CNT_W = 6;

	lbls_pkg::lane_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic neg_q, zero_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [lbls_pkg::LOG_W:0] den_q;
	lbls_pkg::level_t level_q;
	lbls_pkg::energy_t e_q;
	lbls_pkg::log_t le, lmin, lmax;
	logic signed [lbls_pkg::LOG_W:0] dn, dd;
	logic [NUM_W-1:0] rem_sh;
	lbls_pkg::level_t norm;
	logic signed [18:0] diff;
	logic signed [37:0] prod;
	logic signed [21:0] upd;

	assign le = lbls_pkg::mitchell_log(e_q);
	assign lmin = lbls_pkg::mitchell_log(range[31:0]);
	assign lmax = lbls_pkg::mitchell_log(range[63:32]);
	assign dn = $signed({1'b0, le}) - $signed({1'b0, lmin});
	assign dd = $signed({1'b0, lmax}) - $signed({1'b0, lmin});
	assign rem_sh = {rem_q[NUM_W-2:0], num_q[NUM_W-1]};

	// Quotient is truncated toward zero; a negative one or a zero denominator gives zero, one above 1.0 clamps to 1.0.
	always_comb begin
		if (zero_q || neg_q) norm = '0;
		else if (quo_q > NUM_W'(lbls_pkg::ONE_Q16)) norm = lbls_pkg::ONE_Q16;
		else norm = quo_q[lbls_pkg::LEVEL_W-1:0];
	end

	// Smoothing: floor shift of alpha times the difference, then saturate.
	assign diff = $signed({2'b0, norm}) - $signed({2'b0, level_q});
	assign prod = $signed({1'b0, 18'(SMOOTH_ALPHA)}) * diff;
	assign upd = $signed({5'b0, level_q}) + 22'(prod >>> 16);

	always_comb begin
		state_d = state_q;
		case (state_q)
			lbls_pkg::L_IDLE: if (ctl.start) state_d = lbls_pkg::L_LOG;
			lbls_pkg::L_LOG: state_d = lbls_pkg::L_DIV;
			lbls_pkg::L_DIV: if (cnt_q == '0) state_d = lbls_pkg::L_SMOOTH;
			lbls_pkg::L_SMOOTH: state_d = lbls_pkg::L_IDLE;
			default: state_d = lbls_pkg::L_IDLE;
		endcase
	end

	always_comb begin
		sts.busy = (state_q != lbls_pkg::L_IDLE);
		sts.done = (state_q == lbls_pkg::L_SMOOTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbls_pkg::L_IDLE;
			level_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lbls_pkg::L_SMOOTH) begin
				if (upd < 0) level_q <= '0;
				else if (upd > $signed(22'(lbls_pkg::ONE_Q16))) level_q <= lbls_pkg::ONE_Q16;
				else level_q <= upd[lbls_pkg::LEVEL_W-1:0];
			end
		end
	end

	// Operand capture and restoring division on magnitudes.
	always_ff @(posedge clk) begin
		case (state_q)
			lbls_pkg::L_IDLE: if (ctl.start) e_q <= energy;
			lbls_pkg::L_LOG: begin
				zero_q <= (dd == 0);
				neg_q <= (dn[lbls_pkg::LOG_W] ^ dd[lbls_pkg::LOG_W]) && (dn != 0);
				num_q <= {1'b0, (dn < 0) ? -dn : dn, 16'd0};
				den_q <= (dd < 0) ? 23'(-dd) : 23'(dd);
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= CNT_W'(NUM_W - 1);
			end
			lbls_pkg::L_DIV: begin
				num_q <= {num_q[NUM_W-2:0], 1'b0};
				if (rem_sh >= NUM_W'(den_q)) begin
					rem_q <= rem_sh - NUM_W'(den_q);
					quo_q <= {quo_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NUM_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign level = level_q;

	ap_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= lbls_pkg::ONE_Q16) else $error("level out of range");
	ap_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |=> state_q == lbls_pkg::L_IDLE) else $error("done not followed by idle");
	ap_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lbls_pkg::L_IDLE && ctl.start) |=> state_q == lbls_pkg::L_LOG)
		else $error("start lost");
endmodule
`default_nettype wire

// ----- src/log_band_level_smoother_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// log_band_level_smoother_top: log-normalized band level smoother
// Eight lanes normalize and smooth the eight band energies of a frame.
// ----------------------------------------------------------------------------
// One frame passes from acceptance to a valid result through the Mitchell
// logs, the bit-serial divider in each lane, the smoothing update and the
// merge into the output register. All eight lanes run together; a new frame
// is taken the cycle after the result has been taken at the earliest, so
// frames never overlap in the block.
module log_band_level_smoother_top #(
	parameter int SMOOTH_ALPHA = lbls_pkg::DEF_SMOOTH_ALPHA
) (
	input wire logic clk,
	input wire logic arst_n,
	lbls_if.sink in_ch,
	lbls_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [lbls_pkg::RANGE_W-1:0] cfg_data
);
	localparam int NB = lbls_pkg::NUM_BANDS;

	logic [lbls_pkg::RANGE_W-1:0] range_q [NB];
	lbls_pkg::lane_ctl_t ctl;
	lbls_pkg::lane_sts_t sts [NB];
	lbls_pkg::level_t lvl [NB];
	lbls_pkg::energy_t en [NB];
	logic busy_q, out_valid_q;
	logic [NB-1:0] done_v;

	assign en[0] = in_ch.data.sub_bass_energy;
	assign en[1] = in_ch.data.bass_energy;
	assign en[2] = in_ch.data.low_mid_energy;
	assign en[3] = in_ch.data.mid_energy;
	assign en[4] = in_ch.data.high_mid_energy;
	assign en[5] = in_ch.data.presence_energy;
	assign en[6] = in_ch.data.brilliance_energy;
	assign en[7] = in_ch.data.air_energy;

	assign in_ch.ready = !busy_q && !out_valid_q;
	assign ctl.start = in_ch.valid && in_ch.ready;

	// Range registers, one per band.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NB; i++) range_q[i] <= lbls_pkg::RANGE_RESET;
		end else if (cfg_we) begin
			range_q[cfg_index] <= cfg_data;
		end
	end

	genvar g;
	generate
		for (g = 0; g < NB; g++) begin : g_lane
			lbls_lane #(.SMOOTH_ALPHA(SMOOTH_ALPHA)) u_lane (
				.clk(clk), .arst_n(arst_n), .ctl(ctl), .energy(en[g]),
				.range(range_q[g]), .sts(sts[g]), .level(lvl[g])
			);
			assign done_v[g] = sts[g].done;
		end
	endgenerate

	// Merge: lanes finish together; once they are back in idle with updated
	// levels, the result register takes the levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.start) busy_q <= 1'b1;
			else if (!sts[0].busy) busy_q <= 1'b0;
			if (busy_q && !sts[0].busy) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !sts[0].busy) begin
			out_ch.data.sub_bass_level <= lvl[0];
			out_ch.data.bass_level <= lvl[1];
			out_ch.data.low_mid_level <= lvl[2];
			out_ch.data.mid_level <= lvl[3];
			out_ch.data.high_mid_level <= lvl[4];
			out_ch.data.presence_level <= lvl[5];
			out_ch.data.brilliance_level <= lvl[6];
			out_ch.data.air_level <= lvl[7];
		end
	end

	assign out_ch.valid = out_valid_q;

	ap_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		done_v == '0 || done_v == '1) else $error("lanes out of step");
	ap_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && out_valid_q && sts[0].busy)) else $error("overlap");
	ap_nostart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !ctl.start) else $error("start while result held");
endmodule
`default_nettype wire

// ----- verif/tb_log_band_level_smoother_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_log_band_level_smoother_top: band level smoother testbench
// Drives band-energy frames through the request channel under random gaps and
// back-pressure, predicts each set of smoothed levels with an independent
// Mitchell-log normalizer and smoother, and checks every returned level.
// ----------------------------------------------------------------------------
module tb_log_band_level_smoother_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef lbls_pkg::energy_t [lbls_pkg::NUM_BANDS-1:0] band_frame_t;
	typedef lbls_pkg::level_t [lbls_pkg::NUM_BANDS-1:0] band_levels_t;

	localparam int ALPHA = lbls_pkg::DEF_SMOOTH_ALPHA;
	localparam int FRAME_LATENCY = 43;
	localparam longint Q16_ONE = 65536;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [lbls_pkg::RANGE_W-1:0] cfg_data;

	lbls_if #(.payload_t(lbls_pkg::frame_t)) frame_ch ();
	lbls_if #(.payload_t(lbls_pkg::levels_t)) level_ch ();

	log_band_level_smoother_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(frame_ch.sink),
		.out_ch(level_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: band ranges and smoothed levels.
	logic [lbls_pkg::RANGE_W-1:0] band_ranges[lbls_pkg::NUM_BANDS];
	lbls_pkg::level_t band_levels[lbls_pkg::NUM_BANDS];
	band_levels_t pending_levels[$];
	int error_count = 0;
	bit sender_idles = 1;
	bit receiver_idles = 1;
	int receiver_hold = 0;

	string level_names[lbls_pkg::NUM_BANDS] = '{"sub_bass_level", "bass_level",
		"low_mid_level", "mid_level", "high_mid_level", "presence_level",
		"brilliance_level", "air_level"};

	// Clock.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Band array to request payload.
	function automatic lbls_pkg::frame_t pack_frame(input band_frame_t f);
		lbls_pkg::frame_t d;
		d.sub_bass_energy = f[0];
		d.bass_energy = f[1];
		d.low_mid_energy = f[2];
		d.mid_energy = f[3];
		d.high_mid_energy = f[4];
		d.presence_energy = f[5];
		d.brilliance_energy = f[6];
		d.air_energy = f[7];
		return d;
	endfunction

	// Result payload to band array.
	function automatic band_levels_t unpack_levels(input lbls_pkg::levels_t d);
		band_levels_t w;
		w[0] = d.sub_bass_level;
		w[1] = d.bass_level;
		w[2] = d.low_mid_level;
		w[3] = d.mid_level;
		w[4] = d.high_mid_level;
		w[5] = d.presence_level;
		w[6] = d.brilliance_level;
		w[7] = d.air_level;
		return w;
	endfunction

	// Mitchell log2(x + 1.0) in Q6.16.
	function automatic longint log_q16(input lbls_pkg::energy_t x);
		logic [32:0] y;
		int msb;
		longint frac;
		y = {1'b0, x} + 33'd65536;
		msb = 16;
		for (int i = 16; i <= 32; i++) begin
			if (y[i]) msb = i;
		end
		frac = longint'((y - (33'd1 << msb)) >> (msb - 16));
		return (longint'(msb - 16) << 16) + frac;
	endfunction

	// Normalized level of one band, clamped to 0..1.0.
	function automatic longint norm_level(input lbls_pkg::energy_t e,
			input lbls_pkg::energy_t lo, input lbls_pkg::energy_t hi);
		longint le;
		longint lmin;
		longint den;
		longint q;
		le = log_q16(e);
		lmin = log_q16(lo);
		den = log_q16(hi) - lmin;
		if (den == 0) return 0;
		q = ((le - lmin) * Q16_ONE) / den;
		if (q < 0) return 0;
		if (q > Q16_ONE) return Q16_ONE;
		return q;
	endfunction

	// Update the smoothed levels with one frame and return them.
	function automatic band_levels_t smooth_frame(input band_frame_t f);
		band_levels_t res;
		longint prev;
		longint r;
		for (int b = 0; b < lbls_pkg::NUM_BANDS; b++) begin
			prev = longint'(band_levels[b]);
			r = prev + ((longint'(ALPHA) * (norm_level(f[b], band_ranges[b][31:0],
				band_ranges[b][63:32]) - prev)) >>> 16);
			if (r < 0) r = 0;
			if (r > Q16_ONE) r = Q16_ONE;
			band_levels[b] = lbls_pkg::level_t'(r);
			res[b] = band_levels[b];
		end
		return res;
	endfunction

	// Send one frame request and record its expected levels on acceptance.
	task automatic send_frame(input band_frame_t f);
		int gap;
		gap = sender_idles ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.data <= pack_frame(f);
		frame_ch.valid <= 1'b1;
		do @(posedge clk); while (!frame_ch.ready);
		pending_levels.insert(pending_levels.size(), smooth_frame(f));
	endtask

	// Drop valid and wait until every expected result has come back.
	task automatic drain();
		frame_ch.valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic write_range(input int idx, input logic [lbls_pkg::RANGE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= 3'(idx);
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		band_ranges[idx] = val;
		@(posedge clk);
	endtask

	function automatic band_frame_t same_frame(input lbls_pkg::energy_t e);
		band_frame_t f;
		for (int b = 0; b < lbls_pkg::NUM_BANDS; b++) f[b] = e;
		return f;
	endfunction

	// Energy drawn inside the band range half the time, otherwise anywhere.
	function automatic lbls_pkg::energy_t pick_energy(
			input logic [lbls_pkg::RANGE_W-1:0] rng);
		longint lo;
		longint hi;
		longint t;
		lo = longint'(rng[31:0]);
		hi = longint'(rng[63:32]);
		if (lo > hi) begin
			t = lo;
			lo = hi;
			hi = t;
		end
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom >> $urandom_range(0, 31);
			default: return lbls_pkg::energy_t'(lo +
				longint'({$urandom, $urandom} % (hi - lo + 1)));
		endcase
	endfunction

	function automatic logic [lbls_pkg::RANGE_W-1:0] pick_range();
		lbls_pkg::energy_t a;
		lbls_pkg::energy_t b;
		a = $urandom >> $urandom_range(0, 31);
		b = $urandom >> $urandom_range(0, 31);
		case ($urandom_range(0, 5))
			0: return lbls_pkg::RANGE_RESET;
			1: return {a, a};
			2: return {32'hFFFF_FFFF, 32'h0};
			3: return {(a < b) ? a : b, (a < b) ? b : a};
			default: return {(a < b) ? b : a, (a < b) ? a : b};
		endcase
	endfunction

	// Result checker: compare each level with the oldest expectation.
	initial begin
		band_levels_t want;
		band_levels_t got;
		int stall;
		level_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (receiver_hold > 0) begin
				stall = receiver_hold;
				receiver_hold = 0;
			end else begin
				stall = receiver_idles ? $urandom_range(0, 19) : 0;
			end
			if (stall > 0) begin
				level_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			level_ch.ready <= 1'b1;
			do @(posedge clk); while (!level_ch.valid);
			if (pending_levels.size() == 0) begin
				$error("Unexpected level result %h", level_ch.data);
				error_count++;
			end else begin
				want = pending_levels.pop_front();
				got = unpack_levels(level_ch.data);
				for (int b = 0; b < lbls_pkg::NUM_BANDS; b++) begin
					if (got[b] !== want[b]) begin
						$error("%s: expected %0d, got %0d", level_names[b], want[b],
							got[b]);
						error_count++;
					end
				end
			end
		end
	end

	// Reset values: min 0.0, max 1.0 on every band.
	task automatic test_default_ranges();
		lbls_pkg::energy_t vals[10] = '{32'h0, 32'h1, 32'h8000, 32'h1_0000,
			32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'h1_0001, 32'h0};
		band_frame_t f;
		foreach (vals[i]) send_frame(same_frame(vals[i]));
		for (int i = 0; i < 4; i++) begin
			for (int b = 0; b < lbls_pkg::NUM_BANDS; b++)
				f[b] = (b % 2 == i % 2) ? 32'hFFFF_FFFF : 32'h0;
			send_frame(f);
		end
		drain();
	endtask

	// Zero denominator, inverted range, full range and out-of-range energies.
	task automatic test_edge_ranges();
		band_frame_t f;
		write_range(0, {32'h1234_5678, 32'h1234_5678});
		write_range(1, {32'h0001_0000, 32'h0010_0000});
		write_range(2, {32'hFFFF_FFFF, 32'h0});
		write_range(3, {32'h0, 32'hFFFF_FFFF});
		write_range(4, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
		write_range(5, 64'h0);
		write_range(6, {32'h0010_0000, 32'h0002_0000});
		write_range(7, {32'h8000_0000, 32'h0000_8000});
		foreach (f[b]) f[b] = 32'h0;
		send_frame(f);
		send_frame(same_frame(32'hFFFF_FFFF));
		send_frame(same_frame(32'h0008_0000));
		send_frame(same_frame(32'h1234_5678));
		send_frame(same_frame(32'h0000_8000));
		send_frame(same_frame(32'h8000_0000));
		for (int i = 0; i < 4; i++) begin
			foreach (f[b]) f[b] = $urandom;
			send_frame(f);
		end
		drain();
	endtask

	// Random ranges per phase, with energies drawn inside each band's range half the time.
	task automatic test_random_frames(input int phases, input int per_phase);
		band_frame_t f;
		for (int p = 0; p < phases; p++) begin
			for (int b = 0; b < lbls_pkg::NUM_BANDS; b++) write_range(b, pick_range());
			sender_idles = (p % 3 != 1);
			receiver_idles = (p % 4 != 2);
			for (int i = 0; i < per_phase; i++) begin
				foreach (f[b]) f[b] = pick_energy(band_ranges[b]);
				send_frame(f);
			end
			drain();
		end
		sender_idles = 1;
		receiver_idles = 1;
	endtask

	// Long receiver hold so the block stalls its input, then a full pause.
	task automatic test_backpressure();
		band_frame_t f;
		receiver_hold = 400;
		sender_idles = 0;
		for (int i = 0; i < 12; i++) begin
			foreach (f[b]) f[b] = pick_energy(band_ranges[b]);
			send_frame(f);
		end
		sender_idles = 1;
		drain();
		for (int i = 0; i < 12; i++) begin
			foreach (f[b]) f[b] = pick_energy(band_ranges[b]);
			send_frame(f);
		end
		drain();
	endtask

	// Stimulus sequence.
	initial begin
		arst_n = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int b = 0; b < lbls_pkg::NUM_BANDS; b++) begin
			band_ranges[b] = lbls_pkg::RANGE_RESET;
			band_levels[b] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_ranges();
		test_edge_ranges();
		test_backpressure();
		test_random_frames(9, 200);
		repeat (FRAME_LATENCY + 20) @(posedge clk);
		if (error_count == 0 && pending_levels.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
